FILE: rtl/lrupr_pkg.sv
// Package with shared types, constants and defaults for the LRU page replacement core.
package lrupr_pkg;

    // Default values for the top-level parameters.
    localparam int DEF_MAX_FRAMES = 8;
    localparam int DEF_PAGE_BITS  = 16;

    // Fixed field widths of the ports.
    localparam int PAGE_NUM_W = 16;
    localparam int FAULT_W    = 32;
    localparam int CAP_W      = 4;

    // Reset value of the frames_in_use register.
    localparam logic [CAP_W-1:0] CAP_RESET = 4'd3;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic lookup;
        logic commit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

FILE: rtl/lru_page_replacement_core.sv
// Top level of the LRU page replacement core: controller plus datapath.
//
//  Channel   Signals                                       Direction
//  input     in_valid, in_stall, page_number               reference in
//  output    out_valid, out_stall, is_hit, evicted_valid,  result out
//            evicted_page, fault_total
//  config    cfg_valid, cfg_ready, frames_in_use           register write
//
// Each reference passes a lookup step, the parallel tag and rank compare over
// all frames, and an update step, the rank update and frame write.
// A new reference is taken in the same cycle as the previous commit.
// Reset clears all frames, the fault counter and sets frames_in_use to 3.
// A stalled result holds the commit step until the output register frees up.
module lru_page_replacement_core #(
    parameter int MAX_FRAMES = lrupr_pkg::DEF_MAX_FRAMES,
    parameter int PAGE_BITS  = lrupr_pkg::DEF_PAGE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [lrupr_pkg::PAGE_NUM_W-1:0]    page_number,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                is_hit,
    output logic                                evicted_valid,
    output logic [lrupr_pkg::PAGE_NUM_W-1:0]    evicted_page,
    output logic [lrupr_pkg::FAULT_W-1:0]       fault_total,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lrupr_pkg::CAP_W-1:0]         frames_in_use
);

    lrupr_pkg::cmd_t    cmd;
    lrupr_pkg::status_t status;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    lrupr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    lrupr_dp #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_data      (frames_in_use),
        .page_number   (page_number),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .is_hit        (is_hit),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total)
    );

endmodule

FILE: rtl/lrupr_ctrl.sv
// Controller state machine that sequences capture, lookup and commit for each reference.
module lrupr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  lrupr_pkg::status_t status,
    output lrupr_pkg::cmd_t   cmd,
    output logic              in_stall
);

    lrupr_pkg::state_t state_reg;
    lrupr_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrupr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_stall    = 1'b1;
        case (state_reg)
            lrupr_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = lrupr_pkg::ST_LOOKUP;
                end
            end
            lrupr_pkg::ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = lrupr_pkg::ST_UPDATE;
            end
            lrupr_pkg::ST_UPDATE:
            begin
                // The result needs a free output register; a new reference may enter at once.
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    in_stall   = 1'b0;
                    if (in_valid)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = lrupr_pkg::ST_LOOKUP;
                    end
                    else
                    begin
                        state_next = lrupr_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = lrupr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/lrupr_dp.sv
// Datapath with the frame table, recency ranks, fault counter and result register.
module lrupr_dp #(
    parameter int MAX_FRAMES = lrupr_pkg::DEF_MAX_FRAMES,
    parameter int PAGE_BITS  = lrupr_pkg::DEF_PAGE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lrupr_pkg::cmd_t                     cmd,
    output lrupr_pkg::status_t                  status,
    input  logic                                cfg_write,
    input  logic [lrupr_pkg::CAP_W-1:0]         cfg_data,
    input  logic [lrupr_pkg::PAGE_NUM_W-1:0]    page_number,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                is_hit,
    output logic                                evicted_valid,
    output logic [lrupr_pkg::PAGE_NUM_W-1:0]    evicted_page,
    output logic [lrupr_pkg::FAULT_W-1:0]       fault_total
);

    localparam int RANK_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam logic [7:0] MAX_CAP = 8'(MAX_FRAMES);
    localparam logic [lrupr_pkg::FAULT_W-1:0] FAULT_MAX = '1;

    // Frame table and control state.
    logic [MAX_FRAMES-1:0] valid_reg, valid_next;
    logic [PAGE_BITS-1:0]  page_arr_reg [MAX_FRAMES];
    logic [PAGE_BITS-1:0]  page_arr_next [MAX_FRAMES];
    logic [RANK_W-1:0]     rank_reg [MAX_FRAMES];
    logic [RANK_W-1:0]     rank_next [MAX_FRAMES];
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [lrupr_pkg::FAULT_W-1:0] fault_reg, fault_next;
    logic [lrupr_pkg::CAP_W-1:0]   cap_reg, cap_next;

    // Current reference.
    logic [PAGE_BITS-1:0]  cur_page_reg, cur_page_next;

    // Lookup results held for the commit step.
    logic [MAX_FRAMES-1:0] hit_vec_reg, hit_vec_next;
    logic [MAX_FRAMES-1:0] free_vec_reg, free_vec_next;
    logic [MAX_FRAMES-1:0] victim_vec_reg, victim_vec_next;
    logic                  hit_reg, hit_next;
    logic                  use_free_reg, use_free_next;
    logic [RANK_W-1:0]     hit_rank_reg, hit_rank_next;
    logic [RANK_W-1:0]     victim_rank_reg, victim_rank_next;
    logic [PAGE_BITS-1:0]  victim_page_reg, victim_page_next;

    // Result register.
    logic                  out_valid_reg, out_valid_next;
    logic                  is_hit_reg, is_hit_next;
    logic                  ev_valid_reg, ev_valid_next;
    logic [lrupr_pkg::PAGE_NUM_W-1:0] ev_page_reg, ev_page_next;
    logic [lrupr_pkg::FAULT_W-1:0]    fault_out_reg, fault_out_next;

    // Lookup helpers.
    logic [31:0]           page_ext;
    logic [CNT_W-1:0]      count_m1;
    logic [MAX_FRAMES-1:0] inv_vec;
    logic [7:0]            cap8;
    logic [7:0]            eff_cap;
    logic [MAX_FRAMES-1:0] sel_vec;
    logic [RANK_W-1:0]     age_limit;
    logic                  age_all;
    logic                  do_load;
    logic [31:0]           victim_ext;

    assign status.out_free = !out_valid_reg || !out_stall;

    // Capture the page and the configuration register.
    always_comb
    begin
        page_ext      = {16'b0, page_number};
        cur_page_next = cmd.capture ? page_ext[PAGE_BITS-1:0] : cur_page_reg;
        cap_next      = cfg_write ? cfg_data : cap_reg;
    end

    // Associative lookup, victim match and free-frame pick.
    always_comb
    begin
        count_m1         = count_reg - CNT_W'(1);
        inv_vec          = ~valid_reg;
        cap8             = {4'b0, cap_reg};
        if (cap8 == 8'd0)
        begin
            eff_cap = 8'd1;
        end
        else if (cap8 > MAX_CAP)
        begin
            eff_cap = MAX_CAP;
        end
        else
        begin
            eff_cap = cap8;
        end
        hit_vec_next     = hit_vec_reg;
        free_vec_next    = free_vec_reg;
        victim_vec_next  = victim_vec_reg;
        hit_next         = hit_reg;
        use_free_next    = use_free_reg;
        hit_rank_next    = hit_rank_reg;
        victim_rank_next = victim_rank_reg;
        victim_page_next = victim_page_reg;
        if (cmd.lookup)
        begin
            hit_rank_next    = '0;
            victim_page_next = '0;
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                hit_vec_next[i]    = valid_reg[i] && (page_arr_reg[i] == cur_page_reg);
                victim_vec_next[i] = valid_reg[i] && (rank_reg[i] == count_m1[RANK_W-1:0]);
            end
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                if (hit_vec_next[i])
                begin
                    hit_rank_next = hit_rank_next | rank_reg[i];
                end
                if (victim_vec_next[i])
                begin
                    victim_page_next = victim_page_next | page_arr_reg[i];
                end
            end
            free_vec_next    = inv_vec & (~inv_vec + MAX_FRAMES'(1));
            hit_next         = |hit_vec_next;
            use_free_next    = 8'(count_reg) < eff_cap;
            victim_rank_next = count_m1[RANK_W-1:0];
        end
    end

    // Rank aging, frame write and result formation.
    always_comb
    begin
        do_load    = !hit_reg && use_free_reg;
        age_all    = do_load;
        age_limit  = hit_reg ? hit_rank_reg : victim_rank_reg;
        sel_vec    = hit_reg ? hit_vec_reg : (use_free_reg ? free_vec_reg : victim_vec_reg);
        victim_ext = 32'(victim_page_reg);

        valid_next = valid_reg;
        count_next = count_reg;
        fault_next = fault_reg;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            page_arr_next[i] = page_arr_reg[i];
            rank_next[i]     = rank_reg[i];
        end
        is_hit_next    = is_hit_reg;
        ev_valid_next  = ev_valid_reg;
        ev_page_next   = ev_page_reg;
        fault_out_next = fault_out_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cmd.commit)
        begin
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                if (valid_reg[i] && (age_all || rank_reg[i] < age_limit))
                begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
                if (sel_vec[i])
                begin
                    rank_next[i] = '0;
                    if (!hit_reg)
                    begin
                        page_arr_next[i] = cur_page_reg;
                    end
                end
            end
            if (do_load)
            begin
                valid_next = valid_reg | free_vec_reg;
                count_next = count_reg + CNT_W'(1);
            end
            if (!hit_reg && fault_reg != FAULT_MAX)
            begin
                fault_next = fault_reg + 32'd1;
            end
            out_valid_next = 1'b1;
            is_hit_next    = hit_reg;
            ev_valid_next  = !hit_reg && !use_free_reg;
            ev_page_next   = (!hit_reg && !use_free_reg) ? victim_ext[15:0] : '0;
            fault_out_next = fault_next;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            count_reg     <= '0;
            fault_reg     <= '0;
            cap_reg       <= lrupr_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            fault_reg     <= fault_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            page_arr_reg[i] <= page_arr_next[i];
            rank_reg[i]     <= rank_next[i];
        end
        cur_page_reg    <= cur_page_next;
        hit_vec_reg     <= hit_vec_next;
        free_vec_reg    <= free_vec_next;
        victim_vec_reg  <= victim_vec_next;
        hit_reg         <= hit_next;
        use_free_reg    <= use_free_next;
        hit_rank_reg    <= hit_rank_next;
        victim_rank_reg <= victim_rank_next;
        victim_page_reg <= victim_page_next;
        is_hit_reg      <= is_hit_next;
        ev_valid_reg    <= ev_valid_next;
        ev_page_reg     <= ev_page_next;
        fault_out_reg   <= fault_out_next;
    end

    assign out_valid     = out_valid_reg;
    assign is_hit        = is_hit_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign fault_total   = fault_out_reg;

endmodule
